/* sv/tsr_pkg.sv */
// Package for the two-real-spectra split core.
// Field widths, reset values, the bin class type, the staged item and the halving arithmetic.
// No dependencies.
package tsr_pkg;

  localparam int unsigned DATA_W       = 16;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned BIN_W        = 10;
  localparam int unsigned MAX_BINS_DEF = 1024;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]         idx_t;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_LOWER,
    CLS_MIDDLE,
    CLS_UPPER
  } bin_class_t;

  typedef struct packed {
    bin_class_t cls;
    idx_t       k;
    idx_t       m;
    sample_t    zr;
    sample_t    zi;
  } tsr_item_t;

  // floor((a + b) / 2), always fits
  function automatic sample_t add_half(sample_t a, sample_t b);
    logic signed [DATA_W:0] s;
    s = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
    return s[DATA_W:1];
  endfunction

  // floor((a - b) / 2), always fits
  function automatic sample_t sub_half(sample_t a, sample_t b);
    logic signed [DATA_W:0] s;
    s = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    return s[DATA_W:1];
  endfunction

endpackage

/* sv/tsr_if.sv */
// Handshake interfaces for the input bin word and the result word.
// Depends on tsr_pkg.
interface tsr_in_if import tsr_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t z_re;
  sample_t z_im;

  modport source (output valid, output z_re, output z_im, input ready);
  modport sink   (input valid, input z_re, input z_im, output ready);
endinterface

interface tsr_out_if import tsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] bin;
  sample_t          x_re;
  sample_t          x_im;
  sample_t          y_re;
  sample_t          y_im;
  logic             last;

  modport source (output valid, output bin, output x_re, output x_im, output y_re,
                  output y_im, output last, input ready);
  modport sink   (input valid, input bin, input x_re, input x_im, input y_re,
                  input y_im, input last, output ready);
endinterface

/* sv/tsr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module tsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/tsr_ctrl.sv */
// Front end: bin counter, bin classification and lower-half store addressing.
// Depends on tsr_pkg and tsr_in_if.
module tsr_ctrl import tsr_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF,
  parameter int unsigned AW       = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tsr_in_if.sink               in_ch,
  input  logic [CFG_W-1:0]     bin_count,
  input  logic                 free,
  output tsr_item_t            item,
  output logic                 item_v,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [2*DATA_W-1:0]  wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr
);

  idx_t           cnt_r, cnt_nxt;
  idx_t           n_base, n, k, m;
  logic [CFG_W:0] k_inc;
  bin_class_t     cls;
  logic           acc;

  always_comb begin
    n_base = (bin_count == '0) ? CFG_W'(1) : bin_count;
    n      = (32'(n_base) > MAX_BINS) ? CFG_W'(MAX_BINS) : n_base;
    k      = (cnt_r >= n) ? '0 : cnt_r;
    m      = n - k;
    if (k == '0) begin
      cls = CLS_ZERO;
    end else if (k < m) begin
      cls = CLS_LOWER;
    end else if (k == m) begin
      cls = CLS_MIDDLE;
    end else begin
      cls = CLS_UPPER;
    end
    k_inc   = {1'b0, k} + 1'b1;
    cnt_nxt = (k_inc >= {1'b0, n}) ? '0 : k_inc[CFG_W-1:0];
  end

  assign in_ch.ready = free;
  assign acc         = in_ch.valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign item   = '{cls: cls, k: k, m: m, zr: in_ch.z_re, zi: in_ch.z_im};
  assign item_v = acc && (cls != CLS_LOWER);

  assign wr_en   = acc && (cls == CLS_LOWER);
  assign wr_addr = AW'(k);
  assign wr_data = {in_ch.z_im, in_ch.z_re};
  assign rd_en   = acc && (cls == CLS_UPPER);
  assign rd_addr = AW'(m);

endmodule

/* sv/tsr_split.sv */
// Back end: holds one bin with its mirror word, forms one or two results, output register.
// Depends on tsr_pkg and tsr_out_if.
module tsr_split import tsr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  tsr_item_t           item,
  input  logic                item_v,
  input  logic [2*DATA_W-1:0] rd_data,
  output logic                free,
  tsr_out_if.source           out_ch
);

  logic             s1_v_r, s1_sel_r;
  tsr_item_t        s1_r;
  logic             out_v_r, out_last_r;
  logic [BIN_W-1:0] out_bin_r;
  sample_t          out_xr_r, out_xi_r, out_yr_r, out_yi_r;

  sample_t          sr, si, ar, ai, br, bi;
  sample_t          xr, xi, yr, yi;
  logic [BIN_W-1:0] res_bin;
  logic             res_last, out_load;

  assign sr = rd_data[DATA_W-1:0];
  assign si = rd_data[2*DATA_W-1:DATA_W];

  always_comb begin
    ar       = s1_r.zr;
    ai       = s1_r.zi;
    br       = s1_r.zr;
    bi       = s1_r.zi;
    res_bin  = s1_r.k[BIN_W-1:0];
    res_last = 1'b1;
    if (s1_r.cls == CLS_UPPER) begin
      if (!s1_sel_r) begin
        ar       = sr;
        ai       = si;
        res_bin  = s1_r.m[BIN_W-1:0];
        res_last = 1'b0;
      end else begin
        br = sr;
        bi = si;
      end
    end
    if (s1_r.cls == CLS_ZERO) begin
      xr = s1_r.zr;
      xi = '0;
      yr = s1_r.zi;
      yi = '0;
    end else begin
      xr = add_half(ar, br);
      xi = sub_half(ai, bi);
      yr = add_half(ai, bi);
      yi = sub_half(br, ar);
    end
  end

  assign out_load = s1_v_r && (!out_v_r || out_ch.ready);
  assign free     = !s1_v_r || (out_load && res_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s1_sel_r <= 1'b0;
    end else if (item_v) begin
      s1_v_r   <= 1'b1;
      s1_sel_r <= 1'b0;
    end else if (out_load) begin
      if (res_last) begin
        s1_v_r <= 1'b0;
      end else begin
        s1_sel_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_v) begin
      s1_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r  <= res_bin;
      out_xr_r   <= xr;
      out_xi_r   <= xi;
      out_yr_r   <= yr;
      out_yi_r   <= yi;
      out_last_r <= res_last;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.bin   = out_bin_r;
  assign out_ch.x_re  = out_xr_r;
  assign out_ch.x_im  = out_xi_r;
  assign out_ch.y_re  = out_yr_r;
  assign out_ch.y_im  = out_yi_r;
  assign out_ch.last  = out_last_r;

  // a new bin only lands in a free stage
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n) item_v |-> free)
    else $error("bin loaded into busy stage");

  // second result only for an upper bin
  a_sel_upper: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_sel_r) |-> (s1_r.cls == CLS_UPPER))
    else $error("second result for non-upper bin");

  // the mirror word's partner is still held when it leaves
  a_pair_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last) |-> (s1_v_r && s1_sel_r))
    else $error("first result of pair left without partner");

endmodule

/* sv/two_real_spectra_split_core.sv */
// Top level of the two-real-spectra split core.
// Depends on tsr_pkg, tsr_if, tsr_ram, tsr_ctrl and tsr_split.
//
// Takes the bins of one complex spectrum in order 0..N-1 (N = bin_count, 0 acts as 1,
// clamped to MAX_BINS) and returns X and Y of the two packed real signals in Q1.15, each
// result tagged with its bin. Bins from 1 up to below N/2 are kept in a (MAX_BINS+1)/2 x 32
// store (one write and one read port, registered read) and give no result; bin 0 and the middle
// bin of an even N give one result; each upper bin k gives bin N-k then bin k (last set). An
// upper bin holds the block until both results leave the single output register, one per cycle
// while the result port is not stalled; a result passes the held-bin register and the output
// register, and a stalled result port holds off the input. The store needs no clearing after
// reset. The user must write bin_count only while the block is idle; it is not enforced.
module two_real_spectra_split_core import tsr_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  tsr_in_if.sink           in_ch,
  tsr_out_if.source        out_ch
);

  localparam int unsigned DEPTH = ((MAX_BINS + 1) / 2 > 0) ? (MAX_BINS + 1) / 2 : 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_W-1:0]    bin_count_r;
  tsr_item_t           item;
  logic                item_v, free;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [2*DATA_W-1:0] wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      bin_count_r <= cfg_wr_data;
    end
  end

  tsr_ctrl #(
    .MAX_BINS (MAX_BINS),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .bin_count (bin_count_r),
    .free      (free),
    .item      (item),
    .item_v    (item_v),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  tsr_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tsr_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .item_v  (item_v),
    .rd_data (rd_data),
    .free    (free),
    .out_ch  (out_ch)
  );

endmodule

/* verif/tb_two_real_spectra_split_core.sv */
`timescale 1ns / 100ps
// Testbench for two_real_spectra_split_core: random and directed bin frames, results checked
// against a bit-true split predictor held in a small scoreboard class.
// Depends on tsr_pkg, tsr_if and the core with its submodules.

typedef struct packed {
  logic [tsr_pkg::BIN_W-1:0] bin;
  tsr_pkg::sample_t          x_re;
  tsr_pkg::sample_t          x_im;
  tsr_pkg::sample_t          y_re;
  tsr_pkg::sample_t          y_im;
  logic                      last;
} split_word_t;

class bin_split_tracker;
  split_word_t                 due_words[$];
  logic [31:0]                 lower_bins[0:512];
  int unsigned                 next_bin;
  logic [tsr_pkg::CFG_W-1:0]   bin_count;
  int                          errors;

  function new();
    next_bin  = 0;
    bin_count = tsr_pkg::CFG_RESET;
    errors    = 0;
  endfunction

  function void set_count(logic [tsr_pkg::CFG_W-1:0] value);
    bin_count = value;
  endfunction

  function int unsigned frame_len();
    int unsigned n;
    n = bin_count;
    if (n == 0) n = 1;
    if (n > tsr_pkg::MAX_BINS_DEF) n = tsr_pkg::MAX_BINS_DEF;
    return n;
  endfunction

  function int pending();
    return due_words.size();
  endfunction

  function tsr_pkg::sample_t halve(int s);
    return tsr_pkg::sample_t'(s >>> 1);
  endfunction

  // result for bin b from its own value a and its mirror b
  function void push_split(int unsigned b, tsr_pkg::sample_t ar, tsr_pkg::sample_t ai,
                           tsr_pkg::sample_t br, tsr_pkg::sample_t bi, logic last);
    split_word_t w;
    int          a_r, a_i, b_r, b_i;
    a_r = ar;
    a_i = ai;
    b_r = br;
    b_i = bi;
    w.bin  = b[tsr_pkg::BIN_W-1:0];
    w.x_re = halve(a_r + b_r);
    w.x_im = halve(a_i - b_i);
    w.y_re = halve(a_i + b_i);
    w.y_im = halve(b_r - a_r);
    w.last = last;
    due_words.push_back(w);
  endfunction

  function void take_bin(tsr_pkg::sample_t zr, tsr_pkg::sample_t zi);
    int unsigned      n, k, m;
    split_word_t      w;
    tsr_pkg::sample_t sr, si;
    n = frame_len();
    k = next_bin;
    if (k >= n) k = 0;
    m = n - k;
    if (k == 0) begin
      w.bin  = '0;
      w.x_re = zr;
      w.x_im = '0;
      w.y_re = zi;
      w.y_im = '0;
      w.last = 1'b1;
      due_words.push_back(w);
    end else if (k < m) begin
      lower_bins[k] = {zi, zr};
    end else if (k == m) begin
      push_split(k, zr, zi, zr, zi, 1'b1);
    end else begin
      sr = lower_bins[m][15:0];
      si = lower_bins[m][31:16];
      push_split(m, sr, si, zr, zi, 1'b0);
      push_split(k, zr, zi, sr, si, 1'b1);
    end
    k = k + 1;
    next_bin = (k >= n) ? 0 : k;
  endfunction

  function void check_result(split_word_t got);
    split_word_t exp_w;
    if (due_words.size() == 0) begin
      $error("unexpected result word for bin %0d", got.bin);
      errors++;
      return;
    end
    exp_w = due_words.pop_front();
    if (got.bin !== exp_w.bin) begin
      $error("bin: expected %0d, got %0d", exp_w.bin, got.bin);
      errors++;
    end
    if (got.x_re !== exp_w.x_re) begin
      $error("x_re: expected %0d, got %0d", exp_w.x_re, got.x_re);
      errors++;
    end
    if (got.x_im !== exp_w.x_im) begin
      $error("x_im: expected %0d, got %0d", exp_w.x_im, got.x_im);
      errors++;
    end
    if (got.y_re !== exp_w.y_re) begin
      $error("y_re: expected %0d, got %0d", exp_w.y_re, got.y_re);
      errors++;
    end
    if (got.y_im !== exp_w.y_im) begin
      $error("y_im: expected %0d, got %0d", exp_w.y_im, got.y_im);
      errors++;
    end
    if (got.last !== exp_w.last) begin
      $error("last: expected %0d, got %0d", exp_w.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_two_real_spectra_split_core import tsr_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  tsr_in_if  in_ch();
  tsr_out_if out_ch();

  two_real_spectra_split_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  bin_split_tracker sb = new();
  int unsigned      in_gap_max  = 10;
  int unsigned      out_gap_max = 10;
  int unsigned      cycles      = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result sink with random stalls
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = $urandom_range(0, out_gap_max);
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    split_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.bin  = out_ch.bin;
      got.x_re = out_ch.x_re;
      got.x_im = out_ch.x_im;
      got.y_re = out_ch.y_re;
      got.y_im = out_ch.y_im;
      got.last = out_ch.last;
      sb.check_result(got);
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return sample_t'(-1);
      3:       return sample_t'(0);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input sample_t zr, input sample_t zi);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.z_re  <= zr;
    in_ch.z_im  <= zi;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_bin(zr, zi);
  endtask

  // lower bins give no result, so allow the pipeline to empty as well
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_count(value);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_word(rand_sample(), rand_sample());
  endtask

  initial begin : stimulus
    int unsigned      sent;
    bit               big_done;
    bit               big;
    logic [CFG_W-1:0] value;
    int unsigned      len;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.z_re  = '0;
    in_ch.z_im  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset count, partial frame, then a smaller count restarts it
    send_word(sample_t'(-32768), sample_t'(32767));
    send_word(sample_t'(32767), sample_t'(-32768));
    send_word(sample_t'(0), sample_t'(-1));
    send_word(sample_t'(-1), sample_t'(0));
    settle();
    write_count(CFG_W'(3));
    send_word(sample_t'(32767), sample_t'(-32768));
    send_word(sample_t'(32767), sample_t'(-32768));
    send_word(sample_t'(32767), sample_t'(32767));
    settle();
    // zero count behaves as one bin
    write_count(CFG_W'(0));
    send_word(sample_t'(0), sample_t'(0));
    send_word(sample_t'(-1), sample_t'(-1));
    settle();
    write_count(CFG_W'(2));
    send_word(sample_t'(-32768), sample_t'(-32768));
    send_word(sample_t'(32767), sample_t'(-32768));
    settle();
    write_count(CFG_W'(4));
    send_word(sample_t'(1), sample_t'(-1));
    send_word(sample_t'(-32768), sample_t'(32767));
    send_word(sample_t'(-32768), sample_t'(-32768));
    send_word(sample_t'(32767), sample_t'(-32768));
    settle();

    sent     = 0;
    big_done = 1'b0;
    while (sent < 750 || !big_done) begin
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      big = 1'b0;
      if (sb.next_bin != 0) begin
        // frame cut short: new count at or below the position restarts it
        settle();
        write_count(CFG_W'($urandom_range(0, sb.next_bin)));
      end else if (!big_done && sent >= 100) begin
        // above MAX_BINS, clamps to a full-size frame; its first part reaches the upper bins
        big      = 1'b1;
        big_done = 1'b1;
        settle();
        write_count(CFG_W'($urandom_range(1025, 2047)));
      end else if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 19) == 0) value = CFG_W'($urandom_range(513, 600));
        else value = CFG_W'($urandom_range(0, 48));
        settle();
        write_count(value);
      end
      len = sb.frame_len();
      if (big) len = $urandom_range(520, 640);
      else if (len > 1 && $urandom_range(0, 5) == 0) len = $urandom_range(1, len - 1);
      send_random(len);
      sent += len;
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
